// ===== rtl/bfea_pkg.sv =====
// Shared types, constants and helpers of the best-fit extent allocator.
package bfea_pkg;

    localparam int unsigned DEF_MAX_EXTENTS  = 64;
    localparam int unsigned DEF_HEADER_BYTES = 16;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned ALIGN_W  = 13;
    localparam int unsigned ADJ_W    = 14;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 1'b1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } t_entry;

    function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_W] ? '1 : s[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/bfea_if.sv =====
// Request and response channel interfaces of the extent allocator.
interface bfea_req_if
    import bfea_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               func;
    logic [ADDR_W-1:0]  req_size;
    logic [ALIGN_W-1:0] alignment;
    logic [ADDR_W-1:0]  free_addr;
    logic [ADDR_W-1:0]  free_size;
    logic [ADJ_W-1:0]   free_adjust;

    modport source (output valid, func, req_size, alignment, free_addr, free_size,
                    free_adjust, input ready);
    modport sink (input valid, func, req_size, alignment, free_addr, free_size,
                  free_adjust, output ready);
endinterface

interface bfea_rsp_if
    import bfea_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_addr;
    logic [ADDR_W-1:0] charged_size;
    logic [ADJ_W-1:0]  adjust_out;
    logic [ADDR_W-1:0] used_bytes;
    logic [CNT_W-1:0]  live_allocs;

    modport source (output valid, status, alloc_addr, charged_size, adjust_out,
                    used_bytes, live_allocs, input ready);
    modport sink (input valid, status, alloc_addr, charged_size, adjust_out,
                  used_bytes, live_allocs, output ready);
endinterface

// ===== rtl/bfea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfea_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/bfea_adjust.sv =====
// Header adjustment unit: bit-serial remainder, then alignment steps up to the header size.
module bfea_adjust
    import bfea_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [ADDR_W-1:0]  i_start,
    input  logic [ALIGN_W-1:0] i_align,
    output logic               o_done,
    output logic [ADJ_W-1:0]   o_adj
);
    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_DIV  = 4'b0010,
        A_FIX  = 4'b0100,
        A_STEP = 4'b1000
    } t_astate;

    t_astate                     r_state, n_state;
    logic [$clog2(ADDR_W)-1:0]   r_cnt, n_cnt;
    logic [ADDR_W-1:0]           r_dvd, n_dvd;
    logic [ALIGN_W-1:0]          r_div, n_div;
    logic [ALIGN_W-1:0]          r_rem, n_rem;
    logic [ADJ_W-1:0]            r_adj, n_adj;
    logic [ALIGN_W:0]            w_sh;
    logic                        w_below;

    assign w_sh    = {r_rem, r_dvd[ADDR_W-1]};
    assign w_below = r_adj < ADJ_W'(HEADER_BYTES);
    assign o_done  = (r_state == A_STEP) && !w_below;
    assign o_adj   = r_adj;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_div   = r_div;
        n_rem   = r_rem;
        n_adj   = r_adj;
        unique case (r_state)
            A_IDLE: begin
                if (i_go) begin
                    n_dvd   = i_start;
                    n_div   = (i_align == '0) ? ALIGN_W'(1) : i_align;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = A_DIV;
                end
            end
            A_DIV: begin
                // One quotient bit per cycle; only the remainder is kept.
                if (w_sh >= {1'b0, r_div}) begin
                    n_rem = ALIGN_W'(w_sh - {1'b0, r_div});
                end else begin
                    n_rem = w_sh[ALIGN_W-1:0];
                end
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = A_FIX;
                end
            end
            A_FIX: begin
                n_adj   = (r_rem == '0) ? '0 : ADJ_W'(r_div - r_rem);
                n_state = A_STEP;
            end
            A_STEP: begin
                if (w_below) begin
                    n_adj = r_adj + ADJ_W'(r_div);
                end else begin
                    n_state = A_IDLE;
                end
            end
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
        r_adj <= n_adj;
    end
endmodule

// ===== rtl/best_fit_extent_allocator.sv =====
// Top level: sequencer, extent table and counters of the best-fit extent allocator.
//
// Requests arrive on i_req (valid/ready): func selects allocate or free. Every request
// gives exactly one response on o_rsp (valid/ready) with a status, the allocation
// fields and the running byte and allocation counters.
// Requests are served one at a time. An allocate visits every free extent in address
// order; each visit runs the bit-serial remainder unit, then alignment steps until the
// header is cleared. An exact fit ends the walk. Giving a whole extent away moves every
// later entry down by one. A free walks the table entry by entry up to its place, then
// moves up to all later entries. The response sits in an output register: the next
// request is taken while it waits, and the sequencer only holds in its last step when
// the previous response has still not been taken.
// After reset, or after any write to heap_base or heap_size, the table is rebuilt
// as one free extent covering the heap (none if heap_size is zero) and both counters
// are cleared once the sequencer is idle; i_req.ready stays low until this is done.
module best_fit_extent_allocator
    import bfea_pkg::*;
#(
    parameter int unsigned MAX_EXTENTS  = DEF_MAX_EXTENTS,
    parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bfea_req_if.sink             i_req,
    bfea_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data
);
    localparam int unsigned IW = $clog2(MAX_EXTENTS);
    localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_ARD   = 16'h0002,
        S_AWAIT = 16'h0004,
        S_ADJ   = 16'h0008,
        S_AEND  = 16'h0010,
        S_DRD   = 16'h0020,
        S_DWR   = 16'h0040,
        S_FPREP = 16'h0080,
        S_FRD   = 16'h0100,
        S_FCMP  = 16'h0200,
        S_FDEC  = 16'h0400,
        S_FLEFT = 16'h0800,
        S_FLR   = 16'h1000,
        S_URD   = 16'h2000,
        S_UWR   = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    // Control state.
    t_state              r_state, n_state;
    logic                r_pending, n_pending;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [ADDR_W-1:0]   r_hsize, n_hsize;
    logic [CW-1:0]       r_count, n_count;
    logic [ADDR_W-1:0]   r_bytes, n_bytes;
    logic [CNT_W-1:0]    r_allocs, n_allocs;
    logic                r_ovalid, n_ovalid;

    // Request and working registers.
    logic                r_func, n_func;
    logic [ADDR_W-1:0]   r_size, n_size;
    logic [ALIGN_W-1:0]  r_align, n_align;
    logic [ADDR_W-1:0]   r_fsize, n_fsize;
    logic [ADDR_W-1:0]   r_bstart, n_bstart;
    logic [ADDR_W:0]     r_bend, n_bend;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_k, n_k;
    logic                r_found, n_found;
    logic [IW-1:0]       r_bidx, n_bidx;
    logic [ADJ_W-1:0]    r_badj, n_badj;
    logic [ADDR_W:0]     r_btotal, n_btotal;
    t_entry              r_best, n_best;
    t_entry              r_cur, n_cur;
    t_entry              r_prev, n_prev;
    logic [ADDR_W-1:0]   r_msize, n_msize;
    t_status             r_status, n_status;
    logic [ADDR_W-1:0]   r_raddr_res, n_raddr_res;
    logic [ADDR_W-1:0]   r_charged, n_charged;
    logic [ADJ_W-1:0]    r_adj_res, n_adj_res;

    // Output register.
    logic [1:0]          r_o_status, n_o_status;
    logic [ADDR_W-1:0]   r_o_addr, n_o_addr;
    logic [ADDR_W-1:0]   r_o_charged, n_o_charged;
    logic [ADJ_W-1:0]    r_o_adj, n_o_adj;

    // Table and adjustment unit.
    logic                w_we;
    logic [IW-1:0]       w_waddr, w_raddr;
    t_entry              w_wdata;
    logic [$bits(t_entry)-1:0] w_rdata;
    t_entry              w_rd;
    logic                w_adj_go, w_adj_done;
    logic [ADJ_W-1:0]    w_adj;

    logic [ADDR_W:0]     w_total;
    logic [ADDR_W-1:0]   w_rem;
    logic [CW-1:0]       w_km1, w_idxm1;
    logic                w_hascur, w_left, w_load;

    assign w_rd     = t_entry'(w_rdata);
    assign w_total  = {1'b0, r_size} + (ADDR_W + 1)'(w_adj);
    assign w_rem    = r_best.size - r_btotal[ADDR_W-1:0];
    assign w_km1    = r_k - CW'(1);
    assign w_idxm1  = r_idx - CW'(1);
    assign w_hascur = r_idx != r_count;
    assign w_left   = (r_idx != '0) &&
                      (({1'b0, r_prev.start} + {1'b0, r_prev.size}) == {1'b0, r_bstart});
    assign w_load   = (r_state == S_DONE) && (!r_ovalid || o_rsp.ready);

    bfea_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(MAX_EXTENTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    bfea_adjust #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_adjust (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_adj_go),
        .i_start(w_rd.start),
        .i_align(r_align),
        .o_done (w_adj_done),
        .o_adj  (w_adj)
    );

    assign i_req.ready        = (r_state == S_IDLE) && !r_pending;
    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.alloc_addr   = r_o_addr;
    assign o_rsp.charged_size = r_o_charged;
    assign o_rsp.adjust_out   = r_o_adj;
    assign o_rsp.used_bytes   = r_bytes;
    assign o_rsp.live_allocs  = r_allocs;

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_base      = r_base;
        n_hsize     = r_hsize;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_allocs    = r_allocs;
        n_ovalid    = r_ovalid && !o_rsp.ready;
        n_func      = r_func;
        n_size      = r_size;
        n_align     = r_align;
        n_fsize     = r_fsize;
        n_bstart    = r_bstart;
        n_bend      = r_bend;
        n_idx       = r_idx;
        n_k         = r_k;
        n_found     = r_found;
        n_bidx      = r_bidx;
        n_badj      = r_badj;
        n_btotal    = r_btotal;
        n_best      = r_best;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_msize     = r_msize;
        n_status    = r_status;
        n_raddr_res = r_raddr_res;
        n_charged   = r_charged;
        n_adj_res   = r_adj_res;
        n_o_status  = r_o_status;
        n_o_addr    = r_o_addr;
        n_o_charged = r_o_charged;
        n_o_adj     = r_o_adj;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_raddr     = '0;
        w_adj_go    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (r_pending) begin
                    w_we      = 1'b1;
                    w_wdata   = '{start: r_base, size: r_hsize};
                    n_count   = CW'(r_hsize != '0);
                    n_bytes   = '0;
                    n_allocs  = '0;
                    n_pending = 1'b0;
                end else if (i_req.valid) begin
                    n_func      = i_req.func;
                    n_size      = i_req.req_size;
                    n_align     = i_req.alignment;
                    n_fsize     = i_req.free_size;
                    n_bstart    = i_req.free_addr - ADDR_W'(i_req.free_adjust);
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_status    = ST_OK;
                    n_raddr_res = '0;
                    n_charged   = '0;
                    n_adj_res   = '0;
                    n_state     = (i_req.func == FUNC_ALLOC) ? S_ARD : S_FPREP;
                end
            end
            S_ARD: begin
                w_raddr = r_idx[IW-1:0];
                n_state = (r_idx == r_count) ? S_AEND : S_AWAIT;
            end
            S_AWAIT: begin
                n_cur    = w_rd;
                w_adj_go = 1'b1;
                n_state  = S_ADJ;
            end
            S_ADJ: begin
                if (w_adj_done) begin
                    if ({1'b0, r_cur.size} == w_total) begin
                        // Exact fit ends the walk.
                        n_found  = 1'b1;
                        n_bidx   = r_idx[IW-1:0];
                        n_badj   = w_adj;
                        n_btotal = w_total;
                        n_best   = r_cur;
                        n_state  = S_AEND;
                    end else begin
                        if (({1'b0, r_cur.size} > w_total) &&
                            (!r_found || (r_cur.size < r_best.size))) begin
                            n_found  = 1'b1;
                            n_bidx   = r_idx[IW-1:0];
                            n_badj   = w_adj;
                            n_btotal = w_total;
                            n_best   = r_cur;
                        end
                        n_idx   = r_idx + CW'(1);
                        n_state = S_ARD;
                    end
                end
            end
            S_AEND: begin
                if (!r_found) begin
                    n_status = ST_NOFIT;
                    n_state  = S_DONE;
                end else begin
                    n_raddr_res = r_best.start + ADDR_W'(r_badj);
                    n_adj_res   = r_badj;
                    if (w_rem <= ADDR_W'(HEADER_BYTES)) begin
                        // A remainder no bigger than a header goes with the allocation.
                        n_charged = r_best.size;
                        n_k       = CW'(r_bidx) + CW'(1);
                        n_state   = S_DRD;
                    end else begin
                        n_charged = r_btotal[ADDR_W-1:0];
                        w_we      = 1'b1;
                        w_waddr   = r_bidx;
                        w_wdata   = '{start: r_best.start + r_btotal[ADDR_W-1:0],
                                      size: w_rem};
                        n_state   = S_DONE;
                    end
                end
            end
            S_DRD: begin
                w_raddr = r_k[IW-1:0];
                if (r_k == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                w_we    = 1'b1;
                w_waddr = w_km1[IW-1:0];
                w_wdata = w_rd;
                n_k     = r_k + CW'(1);
                n_state = S_DRD;
            end
            S_FPREP: begin
                n_bend  = {1'b0, r_bstart} + {1'b0, r_fsize};
                n_state = S_FRD;
            end
            S_FRD: begin
                w_raddr = r_idx[IW-1:0];
                n_state = (r_idx == r_count) ? S_FDEC : S_FCMP;
            end
            S_FCMP: begin
                if ({1'b0, w_rd.start} < r_bend) begin
                    n_prev  = w_rd;
                    n_idx   = r_idx + CW'(1);
                    n_state = S_FRD;
                end else begin
                    n_cur   = w_rd;
                    n_state = S_FDEC;
                end
            end
            S_FDEC: begin
                if (w_left) begin
                    n_msize = sat_add(r_prev.size, r_fsize);
                    n_state = S_FLEFT;
                end else if (w_hascur && (r_bend == {1'b0, r_cur.start})) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = '{start: r_bstart, size: sat_add(r_fsize, r_cur.size)};
                    n_state = S_DONE;
                end else if (r_count >= CW'(MAX_EXTENTS)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_k     = r_count;
                    n_state = S_URD;
                end
            end
            S_FLEFT: begin
                if (w_hascur &&
                    (({1'b0, r_prev.start} + {1'b0, r_msize}) == {1'b0, r_cur.start})) begin
                    n_msize = sat_add(r_msize, r_cur.size);
                    n_state = S_FLR;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_idxm1[IW-1:0];
                    w_wdata = '{start: r_prev.start, size: r_msize};
                    n_state = S_DONE;
                end
            end
            S_FLR: begin
                // Both neighbors merged: the right entry is removed by shifting down.
                w_we    = 1'b1;
                w_waddr = w_idxm1[IW-1:0];
                w_wdata = '{start: r_prev.start, size: r_msize};
                n_k     = r_idx + CW'(1);
                n_state = S_DRD;
            end
            S_URD: begin
                w_raddr = w_km1[IW-1:0];
                if (r_k == r_idx) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = '{start: r_bstart, size: r_fsize};
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_UWR;
                end
            end
            S_UWR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IW-1:0];
                w_wdata = w_rd;
                n_k     = w_km1;
                n_state = S_URD;
            end
            S_DONE: begin
                if (w_load) begin
                    if (r_status == ST_OK) begin
                        if (r_func == FUNC_ALLOC) begin
                            n_bytes  = r_bytes + r_charged;
                            n_allocs = (&r_allocs) ? r_allocs : r_allocs + CNT_W'(1);
                        end else begin
                            n_bytes  = r_bytes - r_fsize;
                            n_allocs = (r_allocs == '0) ? r_allocs : r_allocs - CNT_W'(1);
                        end
                    end
                    n_o_status  = r_status;
                    n_o_addr    = r_raddr_res;
                    n_o_charged = r_charged;
                    n_o_adj     = r_adj_res;
                    n_ovalid    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEAP_BASE: n_base  = i_cfg_data;
                REG_HEAP_SIZE: n_hsize = i_cfg_data;
                default:       n_base  = r_base;
            endcase
            n_pending = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b1;
            r_base    <= '0;
            r_hsize   <= ADDR_W'(65536);
            r_count   <= '0;
            r_bytes   <= '0;
            r_allocs  <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_base    <= n_base;
            r_hsize   <= n_hsize;
            r_count   <= n_count;
            r_bytes   <= n_bytes;
            r_allocs  <= n_allocs;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_size      <= n_size;
        r_align     <= n_align;
        r_fsize     <= n_fsize;
        r_bstart    <= n_bstart;
        r_bend      <= n_bend;
        r_idx       <= n_idx;
        r_k         <= n_k;
        r_found     <= n_found;
        r_bidx      <= n_bidx;
        r_badj      <= n_badj;
        r_btotal    <= n_btotal;
        r_best      <= n_best;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_msize     <= n_msize;
        r_status    <= n_status;
        r_raddr_res <= n_raddr_res;
        r_charged   <= n_charged;
        r_adj_res   <= n_adj_res;
        r_o_status  <= n_o_status;
        r_o_addr    <= n_o_addr;
        r_o_charged <= n_o_charged;
        r_o_adj     <= n_o_adj;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_EXTENTS))
        else $error("extent count exceeds table depth");

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !r_pending)
        else $error("request accepted before table initialization");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !o_rsp.ready) |=> (r_state == S_DONE))
        else $error("pending response overwritten");

    a_best_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AEND && r_found) |-> (CW'(r_bidx) < r_count))
        else $error("chosen extent outside the table");
`endif
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the best-fit extent allocator.
`timescale 1ns / 1ps

module testbench;
    import bfea_pkg::*;

    localparam int unsigned NUM_EXT = DEF_MAX_EXTENTS;
    localparam int unsigned HDR     = DEF_HEADER_BYTES;

    typedef struct {
        logic               func;
        logic [ADDR_W-1:0]  req_size;
        logic [ALIGN_W-1:0] alignment;
        logic [ADDR_W-1:0]  free_addr;
        logic [ADDR_W-1:0]  free_size;
        logic [ADJ_W-1:0]   free_adjust;
    } t_request;

    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] alloc_addr;
        logic [ADDR_W-1:0] charged_size;
        logic [ADJ_W-1:0]  adjust_out;
        logic [ADDR_W-1:0] used_bytes;
        logic [CNT_W-1:0]  live_allocs;
    } t_response;

    // A live block as the allocator handed it out, kept so that it can be freed later.
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
        logic [ADJ_W-1:0]  adj;
    } t_block;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [ADDR_W-1:0] i_cfg_data;

    bfea_req_if req_if ();
    bfea_rsp_if rsp_if ();

    best_fit_extent_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the allocator state.
    logic [ADDR_W-1:0] heap_base_q;
    logic [ADDR_W-1:0] heap_size_q;
    logic [ADDR_W-1:0] ext_start[NUM_EXT];
    logic [ADDR_W-1:0] ext_size[NUM_EXT];
    int unsigned       ext_count;
    logic [ADDR_W-1:0] bytes_used;
    logic [CNT_W-1:0]  alloc_live;

    t_request  pending_reqs[$];
    t_response expected_rsps[$];
    t_block    live_blocks[$];
    int        error_count;
    bit        idle_free;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic void rebuild_heap();
        ext_start[0] = heap_base_q;
        ext_size[0]  = heap_size_q;
        ext_count    = (heap_size_q != 0) ? 1 : 0;
        bytes_used   = '0;
        alloc_live   = '0;
    endfunction

    function automatic logic [63:0] header_gap(logic [63:0] start, logic [63:0] align);
        logic [63:0] rem;
        logic [63:0] adj;
        rem = start % align;
        adj = (rem != 0) ? align - rem : 0;
        if (adj < HDR) adj += align * ((HDR - adj + align - 1) / align);
        return adj;
    endfunction

    function automatic logic [ADDR_W-1:0] clamp_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'hFFFF_FFFF) ? '1 : s[ADDR_W-1:0];
    endfunction

    function automatic void drop_extent(int unsigned idx);
        for (int unsigned k = idx; k + 1 < ext_count; k++) begin
            ext_start[k] = ext_start[k + 1];
            ext_size[k]  = ext_size[k + 1];
        end
        ext_count--;
    endfunction

    function automatic t_response allocate_block(logic [63:0] size, logic [63:0] align);
        t_response r;
        int unsigned best;
        bit found;
        logic [63:0] best_adj, best_total, adj, total, charged;
        r = '{ST_OK, '0, '0, '0, '0, '0};
        best = 0;
        found = 0;
        best_adj = 0;
        best_total = 0;
        if (align == 0) align = 1;
        for (int unsigned i = 0; i < ext_count; i++) begin
            adj = header_gap(ext_start[i], align);
            total = size + adj;
            if (ext_size[i] == total) begin
                best = i; best_adj = adj; best_total = total; found = 1;
                break;
            end
            if (ext_size[i] > total && (!found || ext_size[i] < ext_size[best])) begin
                best = i; best_adj = adj; best_total = total; found = 1;
            end
        end
        if (!found) begin
            r.status = ST_NOFIT;
            return r;
        end
        r.alloc_addr = ext_start[best] + best_adj[ADDR_W-1:0];
        if (64'(ext_size[best]) - best_total <= HDR) begin
            charged = ext_size[best];
            drop_extent(best);
        end else begin
            charged = best_total;
            ext_start[best] = ext_start[best] + best_total[ADDR_W-1:0];
            ext_size[best]  = ext_size[best] - best_total[ADDR_W-1:0];
        end
        bytes_used += charged[ADDR_W-1:0];
        if (alloc_live != '1) alloc_live++;
        r.charged_size = charged[ADDR_W-1:0];
        r.adjust_out   = best_adj[ADJ_W-1:0];
        return r;
    endfunction

    function automatic t_status release_block(logic [ADDR_W-1:0] addr,
                                              logic [ADDR_W-1:0] size,
                                              logic [ADJ_W-1:0] adj);
        logic [ADDR_W-1:0] bstart;
        logic [63:0] bend;
        int unsigned p;
        int unsigned l;
        bstart = addr - ADDR_W'(adj);
        bend = 64'(bstart) + 64'(size);
        p = 0;
        while (p < ext_count && 64'(ext_start[p]) < bend) p++;
        if (p > 0 && 64'(ext_start[p-1]) + 64'(ext_size[p-1]) == 64'(bstart)) begin
            l = p - 1;
            ext_size[l] = clamp_sum(ext_size[l], size);
            if (p < ext_count &&
                64'(ext_start[l]) + 64'(ext_size[l]) == 64'(ext_start[p])) begin
                ext_size[l] = clamp_sum(ext_size[l], ext_size[p]);
                drop_extent(p);
            end
        end else if (p < ext_count && bend == 64'(ext_start[p])) begin
            ext_start[p] = bstart;
            ext_size[p]  = clamp_sum(size, ext_size[p]);
        end else begin
            if (ext_count >= NUM_EXT) return ST_FULL;
            for (int unsigned k = ext_count; k > p; k--) begin
                ext_start[k] = ext_start[k-1];
                ext_size[k]  = ext_size[k-1];
            end
            ext_start[p] = bstart;
            ext_size[p]  = size;
            ext_count++;
        end
        bytes_used -= size;
        if (alloc_live != 0) alloc_live--;
        return ST_OK;
    endfunction

    function automatic void predict_response(t_request q);
        t_response r;
        if (q.func == FUNC_ALLOC) begin
            r = allocate_block(q.req_size, q.alignment);
            if (r.status == ST_OK)
                live_blocks.push_back('{r.alloc_addr, r.charged_size, r.adjust_out});
        end else begin
            r = '{ST_OK, '0, '0, '0, '0, '0};
            r.status = release_block(q.free_addr, q.free_size, q.free_adjust);
        end
        r.used_bytes  = bytes_used;
        r.live_allocs = alloc_live;
        expected_rsps.push_back(r);
    endfunction

    function automatic t_request alloc_req(logic [ADDR_W-1:0] size, logic [ALIGN_W-1:0] al);
        return '{FUNC_ALLOC, size, al, $urandom, $urandom, ADJ_W'($urandom)};
    endfunction

    function automatic t_request free_req(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] size,
                                          logic [ADJ_W-1:0] adj);
        return '{FUNC_FREE, $urandom, ALIGN_W'($urandom), addr, size, adj};
    endfunction

    // Driver: the prediction is made when a transaction is accepted, in request order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) predict_response(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && (idle_free || $urandom_range(99) >= 7) &&
                !(req_if.valid && req_if.ready && pending_reqs.size() == 0)) begin
                req_if.valid       <= 1'b1;
                req_if.func        <= pending_reqs[0].func;
                req_if.req_size    <= pending_reqs[0].req_size;
                req_if.alignment   <= pending_reqs[0].alignment;
                req_if.free_addr   <= pending_reqs[0].free_addr;
                req_if.free_size   <= pending_reqs[0].free_size;
                req_if.free_adjust <= pending_reqs[0].free_adjust;
            end else if (!req_if.valid || req_if.ready) begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_response e;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response transaction");
                    error_count++;
                end else begin
                    e = expected_rsps.pop_front();
                    if (rsp_if.status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, rsp_if.status);
                        error_count++;
                    end
                    if (rsp_if.alloc_addr !== e.alloc_addr) begin
                        $error("alloc_addr: expected %h, actual %h", e.alloc_addr,
                               rsp_if.alloc_addr);
                        error_count++;
                    end
                    if (rsp_if.charged_size !== e.charged_size) begin
                        $error("charged_size: expected %h, actual %h", e.charged_size,
                               rsp_if.charged_size);
                        error_count++;
                    end
                    if (rsp_if.adjust_out !== e.adjust_out) begin
                        $error("adjust_out: expected %0d, actual %0d", e.adjust_out,
                               rsp_if.adjust_out);
                        error_count++;
                    end
                    if (rsp_if.used_bytes !== e.used_bytes) begin
                        $error("used_bytes: expected %h, actual %h", e.used_bytes,
                               rsp_if.used_bytes);
                        error_count++;
                    end
                    if (rsp_if.live_allocs !== e.live_allocs) begin
                        $error("live_allocs: expected %0d, actual %0d", e.live_allocs,
                               rsp_if.live_allocs);
                        error_count++;
                    end
                end
            end
            rsp_if.ready <= idle_free || ($urandom_range(99) >= 7);
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_HEAP_BASE) heap_base_q = val;
        else heap_size_q = val;
        rebuild_heap();
        @(posedge i_clk);
    endtask

    // Mostly allocations and frees of real blocks, plus a little noise.
    task automatic random_phase(int n, int unsigned max_req);
        int unsigned k;
        int unsigned sel;
        t_block b;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                pending_reqs.push_back(alloc_req($urandom_range(max_req, 1),
                    ($urandom_range(3) == 0) ? ALIGN_W'($urandom) :
                    ALIGN_W'(1 << $urandom_range(12))));
            end else if (sel < 92 && live_blocks.size() > 0) begin
                wait_drained();
                k = $urandom_range(live_blocks.size() - 1);
                b = live_blocks[k];
                live_blocks.delete(k);
                pending_reqs.push_back(free_req(b.addr, b.size, b.adj));
            end else begin
                pending_reqs.push_back(free_req($urandom, $urandom_range(max_req),
                                                ADJ_W'($urandom)));
            end
        end
        wait_drained();
    endtask

    initial begin
        bit fail;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_HEAP_BASE;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.func = FUNC_ALLOC;
        req_if.req_size = '0;
        req_if.alignment = '0;
        req_if.free_addr = '0;
        req_if.free_size = '0;
        req_if.free_adjust = '0;
        rsp_if.ready = 1'b0;
        error_count = 0;
        idle_free = 0;
        heap_base_q = '0;
        heap_size_q = 32'd65536;
        rebuild_heap();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed: zero alignment, large alignments, extremes, no fit.
        pending_reqs.push_back(alloc_req(32'd100, 13'd0));
        pending_reqs.push_back(alloc_req(32'd200, 13'd4096));
        pending_reqs.push_back(alloc_req(32'd77, 13'd4095));
        pending_reqs.push_back(alloc_req(32'hFFFF_FFFF, 13'h1FFF));
        pending_reqs.push_back(alloc_req(32'd1, 13'd3));
        wait_drained();
        foreach (live_blocks[i])
            pending_reqs.push_back(free_req(live_blocks[i].addr, live_blocks[i].size,
                                            live_blocks[i].adj));
        live_blocks.delete();
        pending_reqs.push_back(free_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF));
        wait_drained();

        write_reg(REG_HEAP_SIZE, 32'd128);
        pending_reqs.push_back(alloc_req(32'd112, 13'd1));   // exact fit of the whole heap
        pending_reqs.push_back(alloc_req(32'd1, 13'd1));     // empty table
        wait_drained();
        write_reg(REG_HEAP_SIZE, 32'd0);
        pending_reqs.push_back(alloc_req(32'd1, 13'd1));
        wait_drained();
        write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
        write_reg(REG_HEAP_SIZE, 32'hFFFF_FFFF);
        pending_reqs.push_back(alloc_req(32'd300, 13'd64));
        pending_reqs.push_back(alloc_req(32'hFFFF_0000, 13'd1));
        wait_drained();
        live_blocks.delete();

        // Fill the table with many small holes to reach the full-table case.
        write_reg(REG_HEAP_BASE, 32'h1000);
        write_reg(REG_HEAP_SIZE, 32'd65536);
        live_blocks.delete();
        for (int i = 0; i < 140; i++) pending_reqs.push_back(alloc_req(32'd16, 13'd16));
        wait_drained();
        for (int i = 0; i < live_blocks.size(); i += 2)
            pending_reqs.push_back(free_req(live_blocks[i].addr, live_blocks[i].size,
                                            live_blocks[i].adj));
        wait_drained();
        live_blocks.delete();

        write_reg(REG_HEAP_BASE, $urandom);
        write_reg(REG_HEAP_SIZE, 32'd4096);
        idle_free = 1;
        random_phase(300, 600);
        idle_free = 0;
        live_blocks.delete();
        write_reg(REG_HEAP_BASE, 32'h2000_0000);
        write_reg(REG_HEAP_SIZE, 32'd1 << 20);
        random_phase(500, 20000);
        live_blocks.delete();
        write_reg(REG_HEAP_BASE, 32'hFFFF_8000);
        write_reg(REG_HEAP_SIZE, 32'h0001_0000);
        random_phase(250, 3000);

        fail = error_count != 0 || expected_rsps.size() != 0;
        if (!fail)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
